FILE: rtl/core/wrcm_pkg.sv
// Shared constants, types and status struct for the windowed RMS current meter.
`timescale 1ns / 1ps

package wrcm_pkg;

    // field widths
    localparam int SMP_W   = 14;
    localparam int ZERO_W  = 13;
    localparam int SENS_W  = 10;
    localparam int WIN_W   = 13;
    localparam int LINE_W  = 13;
    localparam int RMS_W   = 20;
    localparam int PWR_W   = 23;
    localparam int CFG_W   = 13;

    // calibration
    localparam int CAL_SAMPLES = 50;
    localparam int CALCNT_W    = 6;
    localparam int CALSUM_W    = 19;

    // limits
    localparam int MAX_WINDOW   = 4096;
    localparam int MAX_VALID_MV = 5500;
    localparam int SENS_MIN     = 10;
    localparam int SENS_MAX     = 1000;
    localparam int MILLI        = 1000;
    localparam int RMS_MAX      = 1048575;
    localparam int POWER_MAX    = 8388607;

    // serial divider: dividend is left aligned, one quotient bit per cycle
    localparam int DIV_W  = 52;
    localparam int DVS_W  = 13;
    localparam int DCNT_W = 6;

    // serial multiplier: one multiplier bit per cycle
    localparam int MUL_W  = 20;
    localparam int MCNT_W = 5;

    // serial square root: two radicand bits per cycle
    localparam int SQRT_W  = 26;
    localparam int SCNT_W  = 5;

    // |diff| * 1000 and rms * line voltage widths
    localparam int CUR_W   = 23;
    localparam int PPROD_W = 33;

    // configuration register indexes
    localparam int REG_IDX_W = 2;
    typedef enum logic [REG_IDX_W-1:0] {
        REG_ZERO = 2'd0,
        REG_SENS = 2'd1,
        REG_WIN  = 2'd2,
        REG_LINE = 2'd3
    } t_reg_idx;

    // status of a multi-cycle arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

FILE: rtl/core/wrcm_ifs.sv
// Valid/ready channel interfaces for samples in and window results out.
`timescale 1ns / 1ps

interface wrcm_in_if import wrcm_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [SMP_W-1:0]  sample_mv;
    logic                     sample_ok;

    modport source (output valid, output sample_mv, output sample_ok, input ready);
    modport sink   (input valid, input sample_mv, input sample_ok, output ready);
endinterface

interface wrcm_out_if import wrcm_pkg::*;;
    logic               valid;
    logic               ready;
    logic [RMS_W-1:0]   rms_current_ma;
    logic [PWR_W-1:0]   power_dw;
    logic               window_failed;
    logic [ZERO_W-1:0]  zero_in_use_mv;

    modport source (output valid, output rms_current_ma, output power_dw,
                    output window_failed, output zero_in_use_mv, input ready);
    modport sink   (input valid, input rms_current_ma, input power_dw,
                    input window_failed, input zero_in_use_mv, output ready);
endinterface

FILE: rtl/core/wrcm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module wrcm_div import wrcm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_dividend,   // left aligned
    input  logic [DVS_W-1:0]  i_divisor,
    input  logic [DCNT_W-1:0] i_steps,      // dividend width in bits
    output logic [DIV_W-1:0]  o_quot,
    output t_unit_stat        o_stat
);

    logic [DIV_W-1:0]  r_q;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_done;

    logic [DVS_W:0]    shifted;
    logic [DVS_W:0]    trial;
    logic              ge;

    // remainder stays below the divisor, so the shifted value fits DVS_W+1 bits
    assign shifted = {r_rem, r_q[DIV_W-1]};
    assign ge      = (shifted >= {1'b0, r_dvs});
    assign trial   = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= i_steps;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - DCNT_W'(1);
                if (r_cnt == DCNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_q   <= {r_q[DIV_W-2:0], ge};
            r_rem <= ge ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
        end
    end

    // the aligned dividend's low zeros end up above the quotient bits
    assign o_quot      = r_q;
    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;

endmodule

FILE: rtl/core/wrcm_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module wrcm_mul import wrcm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [MUL_W-1:0]    i_a,
    input  logic [MUL_W-1:0]    i_b,
    output logic [2*MUL_W-1:0]  o_prod,
    output t_unit_stat          o_stat
);

    logic [2*MUL_W-1:0] r_p;    // upper half accumulates, lower half shifts out i_b
    logic [MUL_W-1:0]   r_a;
    logic [MCNT_W-1:0]  r_cnt;
    logic               r_done;
    logic [MUL_W:0]     sum;

    assign sum = {1'b0, r_p[2*MUL_W-1:MUL_W]} + {1'b0, (r_p[0] ? r_a : '0)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= MCNT_W'(MUL_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - MCNT_W'(1);
                if (r_cnt == MCNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_p <= {{MUL_W{1'b0}}, i_b};
            r_a <= i_a;
        end else if (r_cnt != '0) begin
            r_p <= {sum, r_p[MUL_W-1:1]};
        end
    end

    assign o_prod      = r_p;
    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;

endmodule

FILE: rtl/core/wrcm_sqrt.sv
// Digit-serial integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps

module wrcm_sqrt import wrcm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [2*SQRT_W-1:0] i_rad,
    output logic [SQRT_W-1:0]   o_root,
    output t_unit_stat          o_stat
);

    logic [2*SQRT_W-1:0] r_rad;
    logic [SQRT_W+1:0]   r_rem;
    logic [SQRT_W-1:0]   r_root;
    logic [SCNT_W-1:0]   r_cnt;
    logic                r_done;

    logic [SQRT_W+1:0]   rem_sh;
    logic [SQRT_W+1:0]   trial;
    logic                ge;

    // remainder is at most twice the partial root, so its top two bits are zero here
    assign rem_sh = {r_rem[SQRT_W-1:0], r_rad[2*SQRT_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= SCNT_W'(SQRT_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - SCNT_W'(1);
                if (r_cnt == SCNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_cnt != '0) begin
            r_rad  <= {r_rad[2*SQRT_W-3:0], 2'b00};
            r_rem  <= ge ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[SQRT_W-2:0], ge};
        end
    end

    assign o_root      = r_root;
    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;

endmodule

FILE: rtl/core/windowed_rms_current_meter.sv
// Windowed RMS current meter: calibration, per-sample current, window statistics.
// Calibration items: the last one, when it divides for the mean (19 bits), holds off the next transfer.
// Measurement item: an invalid one only passes the window check; a valid one runs a 23-step
//   current divide, then a 20-step serial square, before the next transfer.
// Window end: 52-step mean divide, 26-step root, 20-step power multiply and 33-step divide
//   by 1000; a failed window skips them; a full output stalls.
// Synchronous active-low reset: back to calibration, config at defaults, no result.
`timescale 1ns / 1ps

module windowed_rms_current_meter import wrcm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    wrcm_in_if.sink              i_smp,
    wrcm_out_if.source           o_res
);

    // Sequencer states. Divides and multiplies share serial units; the root has its own.
    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_CALDIV = 11'b00000000010,  // calibration mean
        ST_PREP   = 11'b00000000100,  // |sample - zero| * 1000, start current divide
        ST_CURDIV = 11'b00000001000,  // current = above / sensitivity
        ST_SQMUL  = 11'b00000010000,  // current squared
        ST_WCHK   = 11'b00000100000,  // window count and end check
        ST_MSDIV  = 11'b00001000000,  // mean square
        ST_SQRT   = 11'b00010000000,
        ST_PWMUL  = 11'b00100000000,  // rms * line voltage
        ST_PWDIV  = 11'b01000000000,  // divide by 1000
        ST_EMIT   = 11'b10000000000   // hand to the output register
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [ZERO_W-1:0] r_cfg_zero;
    logic [SENS_W-1:0] r_cfg_sens;
    logic [WIN_W-1:0]  r_cfg_win;
    logic [LINE_W-1:0] r_cfg_line;

    // calibration and window state
    logic                r_cal;
    logic [CALCNT_W-1:0] r_cal_seen;
    logic [CALCNT_W-1:0] r_cal_valid;
    logic [CALSUM_W-1:0] r_cal_sum;
    logic [ZERO_W-1:0]   r_zero;
    logic [WIN_W-1:0]    r_win_seen;
    logic [WIN_W-1:0]    r_win_valid;
    logic [DIV_W-1:0]    r_sq_sum;

    // captured sample
    logic [ZERO_W-1:0] r_mv;
    logic              r_mv_ok;

    // staged result
    logic [RMS_W-1:0] r_res_rms;
    logic [PWR_W-1:0] r_res_pw;
    logic             r_res_fail;

    // output register
    logic              r_out_valid;
    logic [RMS_W-1:0]  r_out_rms;
    logic [PWR_W-1:0]  r_out_pw;
    logic              r_out_fail;
    logic [ZERO_W-1:0] r_out_zero;

    // unit connections
    logic                div_start;
    logic [DIV_W-1:0]    div_dividend;
    logic [DVS_W-1:0]    div_divisor;
    logic [DCNT_W-1:0]   div_steps;
    logic [DIV_W-1:0]    div_quot;
    t_unit_stat          div_stat;

    logic                mul_start;
    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic [2*MUL_W-1:0]  mul_prod;
    t_unit_stat          mul_stat;

    logic                sqrt_start;
    logic [SQRT_W-1:0]   sqrt_root;
    t_unit_stat          sqrt_stat;

    // combinational helpers
    logic                acc;
    logic [ZERO_W-1:0]   mv13;
    logic                smp_ok;
    logic [CALSUM_W-1:0] cal_sum_n;
    logic [CALCNT_W-1:0] cal_valid_n;
    logic [CALCNT_W-1:0] cal_seen_n;
    logic                cal_end;
    logic [ZERO_W-1:0]   zero_sat;
    logic [ZERO_W-1:0]   abs_diff;
    logic [CUR_W-1:0]    x1000;
    logic [SENS_W-1:0]   sens_clamp;
    logic [WIN_W-1:0]    win_size;
    logic [WIN_W-1:0]    win_seen_n;
    logic                win_end;
    logic                win_failed;
    logic [RMS_W-1:0]    rms_clamp;
    logic [PWR_W-1:0]    pw_clamp;
    logic                out_load;

    assign acc         = i_smp.valid && i_smp.ready;
    assign i_smp.ready = (r_state == ST_IDLE);

    // a sample counts only if the source delivered it and it lies in 0..5500 mV
    assign mv13   = i_smp.sample_mv[ZERO_W-1:0];
    assign smp_ok = i_smp.sample_ok && !i_smp.sample_mv[SMP_W-1]
                    && (mv13 <= ZERO_W'(MAX_VALID_MV));

    assign cal_sum_n   = r_cal_sum + (smp_ok ? CALSUM_W'(mv13) : '0);
    assign cal_valid_n = r_cal_valid + CALCNT_W'(smp_ok);
    assign cal_seen_n  = r_cal_seen + CALCNT_W'(1);
    assign cal_end     = (cal_seen_n >= CALCNT_W'(CAL_SAMPLES));
    assign zero_sat    = (r_cfg_zero > ZERO_W'(MAX_VALID_MV)) ? ZERO_W'(MAX_VALID_MV)
                                                              : r_cfg_zero;

    // x * 1000 = x * 1024 - x * 16 - x * 8
    assign abs_diff = (r_mv >= r_zero) ? (r_mv - r_zero) : (r_zero - r_mv);
    assign x1000    = {abs_diff, 10'b0} - CUR_W'({abs_diff, 4'b0})
                      - CUR_W'({abs_diff, 3'b0});

    assign sens_clamp = (r_cfg_sens < SENS_W'(SENS_MIN)) ? SENS_W'(SENS_MIN) :
                        (r_cfg_sens > SENS_W'(SENS_MAX)) ? SENS_W'(SENS_MAX) : r_cfg_sens;

    assign win_size   = (r_cfg_win == '0) ? WIN_W'(1) :
                        (r_cfg_win > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : r_cfg_win;
    assign win_seen_n = r_win_seen + WIN_W'(1);
    // >= so that a window shrunk mid-way ends on the next item
    assign win_end    = (win_seen_n >= win_size);
    assign win_failed = (r_win_valid < (win_size >> 1)) || (r_win_valid == '0);

    assign rms_clamp = (sqrt_root > SQRT_W'(RMS_MAX)) ? RMS_W'(RMS_MAX)
                                                      : sqrt_root[RMS_W-1:0];
    assign pw_clamp  = (div_quot > DIV_W'(POWER_MAX)) ? PWR_W'(POWER_MAX)
                                                      : div_quot[PWR_W-1:0];

    // sequencer and unit launch
    always_comb begin
        n_state      = r_state;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        div_steps    = '0;
        mul_start    = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        sqrt_start   = 1'b0;
        out_load     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    if (r_cal) begin
                        if (cal_end && (cal_valid_n != '0)) begin
                            div_start    = 1'b1;
                            div_dividend = {cal_sum_n, {(DIV_W-CALSUM_W){1'b0}}};
                            div_divisor  = DVS_W'(cal_valid_n);
                            div_steps    = DCNT_W'(CALSUM_W);
                            n_state      = ST_CALDIV;
                        end
                    end else begin
                        n_state = ST_PREP;
                    end
                end
            end
            ST_CALDIV: begin
                if (div_stat.done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_PREP: begin
                if (r_mv_ok) begin
                    div_start    = 1'b1;
                    div_dividend = {x1000, {(DIV_W-CUR_W){1'b0}}};
                    div_divisor  = DVS_W'(sens_clamp);
                    div_steps    = DCNT_W'(CUR_W);
                    n_state      = ST_CURDIV;
                end else begin
                    n_state = ST_WCHK;
                end
            end
            ST_CURDIV: begin
                if (div_stat.done) begin
                    // |current| fits MUL_W bits: 5500 * 1000 / 10
                    mul_start = 1'b1;
                    mul_a     = div_quot[MUL_W-1:0];
                    mul_b     = div_quot[MUL_W-1:0];
                    n_state   = ST_SQMUL;
                end
            end
            ST_SQMUL: begin
                if (mul_stat.done) begin
                    n_state = ST_WCHK;
                end
            end
            ST_WCHK: begin
                if (!win_end) begin
                    n_state = ST_IDLE;
                end else if (win_failed) begin
                    n_state = ST_EMIT;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = r_sq_sum;
                    div_divisor  = DVS_W'(r_win_valid);
                    div_steps    = DCNT_W'(DIV_W);
                    n_state      = ST_MSDIV;
                end
            end
            ST_MSDIV: begin
                if (div_stat.done) begin
                    sqrt_start = 1'b1;
                    n_state    = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (sqrt_stat.done) begin
                    mul_start = 1'b1;
                    mul_a     = MUL_W'(rms_clamp);
                    mul_b     = MUL_W'(r_cfg_line);
                    n_state   = ST_PWMUL;
                end
            end
            ST_PWMUL: begin
                if (mul_stat.done) begin
                    div_start    = 1'b1;
                    div_dividend = {mul_prod[PPROD_W-1:0], {(DIV_W-PPROD_W){1'b0}}};
                    div_divisor  = DVS_W'(MILLI);
                    div_steps    = DCNT_W'(PPROD_W);
                    n_state      = ST_PWDIV;
                end
            end
            ST_PWDIV: begin
                if (div_stat.done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // wait for the output register to free up
                if (!r_out_valid || o_res.ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg_zero  <= ZERO_W'(2500);
            r_cfg_sens  <= SENS_W'(185);
            r_cfg_win   <= WIN_W'(100);
            r_cfg_line  <= LINE_W'(2300);
            r_cal       <= 1'b1;
            r_cal_seen  <= '0;
            r_cal_valid <= '0;
            r_cal_sum   <= '0;
            r_zero      <= '0;
            r_win_seen  <= '0;
            r_win_valid <= '0;
            r_sq_sum    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_idx))
                    REG_ZERO: r_cfg_zero <= i_cfg_data[ZERO_W-1:0];
                    REG_SENS: r_cfg_sens <= i_cfg_data[SENS_W-1:0];
                    REG_WIN:  r_cfg_win  <= i_cfg_data[WIN_W-1:0];
                    REG_LINE: r_cfg_line <= i_cfg_data[LINE_W-1:0];
                    default: ;
                endcase
            end

            // calibration accumulates in the transfer cycle
            if ((r_state == ST_IDLE) && acc && r_cal) begin
                r_cal_sum   <= cal_sum_n;
                r_cal_valid <= cal_valid_n;
                r_cal_seen  <= cal_seen_n;
                if (cal_end && (cal_valid_n == '0)) begin
                    r_zero <= zero_sat;
                    r_cal  <= 1'b0;
                end
            end
            if ((r_state == ST_CALDIV) && div_stat.done) begin
                r_zero <= div_quot[ZERO_W-1:0];
                r_cal  <= 1'b0;
            end

            if ((r_state == ST_SQMUL) && mul_stat.done) begin
                r_sq_sum    <= r_sq_sum + DIV_W'(mul_prod);
                r_win_valid <= r_win_valid + WIN_W'(1);
            end
            if ((r_state == ST_WCHK) && !win_end) begin
                r_win_seen <= win_seen_n;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
                r_win_seen  <= '0;
                r_win_valid <= '0;
                r_sq_sum    <= '0;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && acc) begin
            r_mv    <= mv13;
            r_mv_ok <= smp_ok;
        end
        if ((r_state == ST_WCHK) && win_end && win_failed) begin
            r_res_rms  <= '0;
            r_res_pw   <= '0;
            r_res_fail <= 1'b1;
        end
        if ((r_state == ST_SQRT) && sqrt_stat.done) begin
            r_res_rms <= rms_clamp;
        end
        if ((r_state == ST_PWDIV) && div_stat.done) begin
            r_res_pw   <= pw_clamp;
            r_res_fail <= 1'b0;
        end
        if (out_load) begin
            r_out_rms  <= r_res_rms;
            r_out_pw   <= r_res_pw;
            r_out_fail <= r_res_fail;
            r_out_zero <= r_zero;
        end
    end

    wrcm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_steps    (div_steps),
        .o_quot     (div_quot),
        .o_stat     (div_stat)
    );

    wrcm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_prod  (mul_prod),
        .o_stat  (mul_stat)
    );

    wrcm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   (div_quot),
        .o_root  (sqrt_root),
        .o_stat  (sqrt_stat)
    );

    assign o_res.valid          = r_out_valid;
    assign o_res.rms_current_ma = r_out_rms;
    assign o_res.power_dw       = r_out_pw;
    assign o_res.window_failed  = r_out_fail;
    assign o_res.zero_in_use_mv = r_out_zero;

    // arithmetic units are never relaunched mid-operation
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_mul_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_start |-> !mul_stat.busy)
        else $error("multiplier started while busy");

    a_sqrt_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_start |-> !sqrt_stat.busy)
        else $error("square root started while busy");

    // a pending result is never overwritten
    a_out_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || o_res.ready))
        else $error("output register overwritten");

    a_win_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_win_seen < WIN_W'(MAX_WINDOW))
        else $error("window count out of range");

    a_win_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_win_valid <= r_win_seen))
        else $error("more valid samples than samples in window");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the windowed RMS current meter: calibration, windows, registers.
`timescale 1ns / 1ps

module testbench;
    import wrcm_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 300;    // a valid item plus a full window end, with margin
    localparam int HOLD_CYCLES   = 2000;   // long result-side hold-off, fills the block
    localparam int IDLE_PCT      = 16;
    localparam int RANDOM_ITEMS  = 420;

    typedef struct packed {
        logic signed [SMP_W-1:0] mv;
        logic                    ok;
    } t_sample;

    typedef struct packed {
        logic [RMS_W-1:0]  rms;
        logic [PWR_W-1:0]  pwr;
        logic              failed;
        logic [ZERO_W-1:0] zero;
    } t_reading;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [REG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    wrcm_in_if  smp_ch ();
    wrcm_out_if res_ch ();

    windowed_rms_current_meter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_smp      (smp_ch),
        .o_res      (res_ch)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Stimulus and scoreboard storage
    // ------------------------------------------------------------------
    t_sample  pending_samples[$];    // fed by the sequence, drained by the driver
    t_reading expected_readings[$];  // oldest first

    int queued_cnt    = 0;
    int accepted_cnt  = 0;
    int readings_seen = 0;
    int failed_seen   = 0;
    int errors        = 0;
    int cycle_cnt     = 0;
    int phases_run    = 0;

    int idle_pct;          // shared by both sides
    bit stall_armed;       // asks the result side for one long hold-off
    bit in_taken;          // a sample transfer happened at the last rising edge

    // ------------------------------------------------------------------
    // Meter model: its own copy of the registers and state
    // ------------------------------------------------------------------
    logic [ZERO_W-1:0] cfg_zero = 13'd2500;
    logic [SENS_W-1:0] cfg_sens = 10'd185;
    logic [WIN_W-1:0]  cfg_win  = 13'd100;
    logic [LINE_W-1:0] cfg_line = 13'd2300;

    bit              cal_done  = 1'b0;
    int              cal_items = 0;
    int              cal_good  = 0;
    int              cal_acc   = 0;
    int              zero_mv   = 0;
    int              win_items = 0;
    int              win_good  = 0;
    longint unsigned sq_acc    = 0;

    // floor(sqrt(v)), one result bit at a time from the top
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        int              b;
        root = 0;
        for (b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // Advance the model by one accepted sample; queue a reading at a window end.
    function automatic void predict_reading(t_sample s);
        int              mv;
        int              sens;
        int              size;
        bit              good;
        longint          cur;
        longint unsigned root;
        longint unsigned watts;
        t_reading        r;

        mv   = $signed(s.mv);
        good = s.ok && mv >= 0 && mv <= MAX_VALID_MV;

        if (!cal_done) begin
            if (good) begin
                cal_acc += mv;
                cal_good++;
            end
            cal_items++;
            if (cal_items >= CAL_SAMPLES) begin
                // no usable sample: fall back to the register, capped at full scale
                if (cal_good > 0)
                    zero_mv = cal_acc / cal_good;
                else
                    zero_mv = (cfg_zero > MAX_VALID_MV) ? MAX_VALID_MV : int'(cfg_zero);
                cal_done = 1'b1;
            end
            return;
        end

        sens = cfg_sens;
        if (sens < SENS_MIN) sens = SENS_MIN;
        if (sens > SENS_MAX) sens = SENS_MAX;
        size = cfg_win;
        if (size < 1) size = 1;
        if (size > MAX_WINDOW) size = MAX_WINDOW;

        if (good) begin
            cur = (longint'(mv) - longint'(zero_mv)) * MILLI / longint'(sens);
            if (cur < 0) cur = -cur;
            sq_acc += cur * cur;
            win_good++;
        end
        win_items++;
        if (win_items < size)
            return;

        r.failed = (win_good < size / 2) || (win_good == 0);
        r.zero   = zero_mv[ZERO_W-1:0];
        r.rms    = '0;
        r.pwr    = '0;
        if (!r.failed) begin
            root = int_sqrt(sq_acc / win_good);
            if (root > RMS_MAX) root = RMS_MAX;
            watts = root * cfg_line / MILLI;
            if (watts > POWER_MAX) watts = POWER_MAX;
            r.rms = root[RMS_W-1:0];
            r.pwr = watts[PWR_W-1:0];
        end
        expected_readings.push_back(r);
        win_items = 0;
        win_good  = 0;
        sq_acc    = 0;
    endfunction

    function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Sample driver: changes on the falling edge, holds until transfer
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_sample next_smp;
        if (!i_rst_n) begin
            smp_ch.valid <= 1'b0;
        end else if (!smp_ch.valid || in_taken) begin
            if (pending_samples.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                next_smp = pending_samples.pop_front();
                smp_ch.valid     <= 1'b1;
                smp_ch.sample_mv <= next_smp.mv;
                smp_ch.sample_ok <= next_smp.ok;
            end else begin
                smp_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result-side ready: random gaps plus one long hold-off on request
    // ------------------------------------------------------------------
    int hold_left   = 0;
    bit stall_taken = 1'b0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            res_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (stall_armed && !stall_taken && res_ch.valid) begin
            // block keeps taking samples until its output register is full
            res_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            stall_taken  <= 1'b1;
        end else begin
            res_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sampled on the rising edge; result check before prediction,
    // since a sample taken at this edge cannot have its reading out yet
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= smp_ch.valid && smp_ch.ready;
            if (res_ch.valid && res_ch.ready) begin
                if (expected_readings.size() == 0) begin
                    errors++;
                    $display("%0t: reading with none expected: rms=%0d power=%0d",
                             $time, res_ch.rms_current_ma, res_ch.power_dw);
                    $display("%0t:   failed=%0d zero=%0d",
                             $time, res_ch.window_failed, res_ch.zero_in_use_mv);
                end else begin
                    want = expected_readings.pop_front();
                    check_field("rms_current_ma", want.rms,    res_ch.rms_current_ma);
                    check_field("power_dw",       want.pwr,    res_ch.power_dw);
                    check_field("window_failed",  want.failed, res_ch.window_failed);
                    check_field("zero_in_use_mv", want.zero,   res_ch.zero_in_use_mv);
                    readings_seen++;
                    if (want.failed) failed_seen++;
                end
            end
            if (smp_ch.valid && smp_ch.ready) begin
                predict_reading('{mv: smp_ch.sample_mv, ok: smp_ch.sample_ok});
                accepted_cnt++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d readings still due",
                     $time, cycle_cnt, expected_readings.size());
            $display("windowed_rms_current_meter verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence helpers
    // ------------------------------------------------------------------
    task automatic write_reg(t_reg_idx idx, int value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[CFG_W-1:0];
        // block is idle, so the model copy can change right away
        case (idx)
            REG_ZERO: cfg_zero = value[ZERO_W-1:0];
            REG_SENS: cfg_sens = value[SENS_W-1:0];
            REG_WIN:  cfg_win  = value[WIN_W-1:0];
            REG_LINE: cfg_line = value[LINE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(int zero, int sens, int win, int line);
        write_reg(REG_ZERO, zero);
        write_reg(REG_SENS, sens);
        write_reg(REG_WIN,  win);
        write_reg(REG_LINE, line);
        phases_run++;
    endtask

    task automatic queue_sample(int mv, bit ok);
        t_sample s;
        s.mv = mv[SMP_W-1:0];
        s.ok = ok;
        pending_samples.push_back(s);
        queued_cnt++;
    endtask

    // bad_pct: share of discarded samples; valid ones cluster around center
    task automatic queue_random(int bad_pct, int center);
        int pick;
        int mv;
        pick = $urandom_range(0, 99);
        if (pick >= bad_pct) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                mv = $urandom_range(0, 1) ? MAX_VALID_MV : 0;
            end else if (pick < 6) begin
                mv = center + int'($urandom_range(0, 1200)) - 600;
                if (mv < 0) mv = 0;
                if (mv > MAX_VALID_MV) mv = MAX_VALID_MV;
            end else begin
                mv = $urandom_range(0, MAX_VALID_MV);
            end
            queue_sample(mv, 1'b1);
        end else begin
            pick = $urandom_range(0, 2);
            if (pick == 0)
                queue_sample(int'($urandom_range(0, 16383)) - 8192, 1'b0);
            else if (pick == 1)
                queue_sample(-int'($urandom_range(1, 8192)), 1'b1);
            else
                queue_sample($urandom_range(MAX_VALID_MV + 1, 8191), 1'b1);
        end
    endtask

    // sender pause: everything taken, every reading back, block quiet
    task automatic settle();
        while (accepted_cnt != queued_cnt || expected_readings.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int cal_mode;
        int i;
        int pick;
        int win;
        int sens;
        int count;
        int bad_pct;
        int phase;
        int rand_items;

        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = REG_ZERO;
        i_cfg_data       = '0;
        smp_ch.valid     = 1'b0;
        smp_ch.sample_mv = '0;
        smp_ch.sample_ok = 1'b0;
        res_ch.ready     = 1'b0;
        idle_pct         = IDLE_PCT;
        stall_armed      = 1'b0;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Calibration happens once per reset: either a real mean of valid
        // samples or, with nothing valid, the register value (capped).
        cal_mode = $urandom_range(0, 1);
        set_regs($urandom_range(0, 1) ? $urandom_range(MAX_VALID_MV + 1, 8191)
                                      : $urandom_range(0, MAX_VALID_MV),
                 SENS_MIN, 100, 2300);
        queue_sample(0, cal_mode);
        queue_sample(MAX_VALID_MV, cal_mode);
        queue_sample(-8192, 1'b1);
        queue_sample(8191, 1'b1);
        queue_sample(-1, 1'b1);
        queue_sample(MAX_VALID_MV + 1, 1'b1);
        for (i = 6; i < CAL_SAMPLES; i++)
            queue_random(cal_mode ? 20 : 100, 2500);
        settle();

        // One-sample windows: field extremes and each discard reason,
        // sensitivity clamped up to the minimum, top line voltage.
        set_regs(0, 0, 0, 8191);
        queue_sample(0, 1'b1);
        queue_sample(MAX_VALID_MV, 1'b1);
        queue_sample(8191, 1'b1);
        queue_sample(-8192, 1'b1);
        queue_sample(-1, 1'b1);
        queue_sample(MAX_VALID_MV + 1, 1'b1);
        queue_sample(2000, 1'b0);
        queue_sample(zero_mv, 1'b1);
        settle();

        // Two-sample windows, sensitivity clamped down, no line voltage:
        // one valid of two passes, none fails.
        set_regs(8191, 1023, 2, 0);
        queue_sample(3000, 1'b1);
        queue_sample(100, 1'b0);
        queue_sample(-5, 1'b1);
        queue_sample(6000, 1'b1);
        settle();

        // Largest window, then past range, then shrunk so the open window
        // closes on the very next sample.
        set_regs(MAX_VALID_MV, 185, MAX_WINDOW, 5000);
        repeat (6) queue_random(0, zero_mv);
        settle();
        write_reg(REG_WIN, 8191);
        repeat (3) queue_random(30, zero_mv);
        settle();
        write_reg(REG_WIN, 3);
        queue_sample(MAX_VALID_MV, 1'b1);
        settle();

        // Three-sample windows: one valid is just enough, none fails.
        set_regs(0, SENS_MIN, 3, 2300);
        queue_sample(4000, 1'b1);
        queue_sample(4000, 1'b0);
        queue_sample(-300, 1'b1);
        queue_sample(9, 1'b0);
        queue_sample(5600, 1'b1);
        queue_sample(-8192, 1'b0);
        settle();

        // Random phases. Mostly short windows with mostly valid samples;
        // some noisy phases, some huge windows cut short by the next phase.
        phase      = 0;
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)      win = $urandom_range(1, 8);
            else if (pick < 85) win = $urandom_range(9, 40);
            else if (pick < 92) win = 0;
            else                win = $urandom_range(41, 8191);
            pick = $urandom_range(0, 99);
            if (pick < 10)      sens = $urandom_range(0, SENS_MIN - 1);
            else if (pick < 20) sens = $urandom_range(SENS_MAX + 1, 1023);
            else                sens = $urandom_range(SENS_MIN, SENS_MAX);
            count   = $urandom_range(8, 45);
            bad_pct = ($urandom_range(0, 3) == 0) ? 55 : 8;

            // phase 2: long run without gaps on either side
            idle_pct = (phase == 2) ? 0 : IDLE_PCT;
            if (phase == 2) count = 80;
            // phase 5: every sample closes a window while results are held off
            stall_armed = (phase == 5);
            if (phase == 5) begin
                win   = 1;
                count = 40;
            end

            set_regs($urandom_range(0, 8191), sens, win, $urandom_range(0, 8191));
            repeat (count) queue_random(bad_pct, zero_mv);
            rand_items += count;
            settle();
            phase++;
        end

        $display("Ran %0d samples (%0d for calibration) over %0d register settings;",
                 accepted_cnt, CAL_SAMPLES, phases_run);
        $display("checked %0d window readings, %0d of them failed windows, zero point %0d mV.",
                 readings_seen, failed_seen, zero_mv);
        if (errors == 0) begin
            $display("windowed_rms_current_meter verification clean");
        end else begin
            $display("windowed_rms_current_meter verification failed");
        end
        $finish;
    end

endmodule
